>>> rtl/lppd_pkg.sv
// Package for the length-prefixed packet deframer.
// Holds character codes, status codes and the result word type.
// No dependencies.
`timescale 1ns / 1ps
package lppd_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SIX   = 8'h36;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_ERROR   = 2'd1;
  localparam logic [1:0] STATUS_BADTYPE = 2'd2;

  typedef struct packed {
    logic [2:0] packet_type;
    logic [7:0] data_byte;
    logic       has_data;
    logic       packet_last;
    logic [1:0] status;
  } result_t;

endpackage

>>> rtl/length_prefixed_packet_deframer.sv
// Top level of the length-prefixed packet deframer.
// Depends on lppd_pkg and lppd_parse.
`timescale 1ns / 1ps
// Deframes a text payload of "<decimal length>:<type digit><data...>" packets,
// one byte word per cycle unless stalled. Each input word passes an input
// register, the parser decodes it against the framing state in one pass, and
// any result is captured in an output register. Throughput is one word per
// cycle while out_stall is low; out_valid rises once a result has moved from
// the parser into the output register. The output register's occupancy is
// the only thing that stalls the input. One result word per data byte, with the
// packet type and a last mark; a type digit with no data gives one word with
// has_data low. Length errors, zero lengths and non-digit types report status
// 1, a type digit 7..9 reports status 2, and either halts parsing until the
// word that carries in_payload_end, which always restarts the parser.
// LENGTH_BITS sets the width of the length counter; longer lengths are errors.
module length_prefixed_packet_deframer #(
  parameter int LENGTH_BITS = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_payload_byte,
  input  logic       in_payload_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_packet_type,
  output logic [7:0] out_data_byte,
  output logic       out_has_data,
  output logic       out_packet_last,
  output logic [1:0] out_status
);

  logic               s1_valid_r, s1_valid_nxt;
  logic [7:0]         s1_byte_r;
  logic               s1_end_r;
  logic               out_valid_r, out_valid_nxt;
  lppd_pkg::result_t  out_r;
  logic               out_ready;
  logic               s1_load;
  logic               step;
  logic               res_valid;
  lppd_pkg::result_t  res;

  // Output register frees up when empty or being taken this cycle.
  assign out_ready = !out_valid_r || !out_stall;
  // Advance the held word through the parser only when its result has a home.
  assign step      = s1_valid_r && out_ready;
  assign s1_load   = !s1_valid_r || out_ready;
  assign in_stall  = !s1_load;

  assign s1_valid_nxt  = s1_load ? in_valid : s1_valid_r;
  assign out_valid_nxt = out_ready ? (step && res_valid) : out_valid_r;

  lppd_parse #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_in   (s1_byte_r),
    .pend      (s1_end_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on acceptance, result register on a new result; hold otherwise.
  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_byte_r <= in_payload_byte;
      s1_end_r  <= in_payload_end;
    end
    if (step && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_packet_type = out_r.packet_type;
  assign out_data_byte   = out_r.data_byte;
  assign out_has_data    = out_r.has_data;
  assign out_packet_last = out_r.packet_last;
  assign out_status      = out_r.status;

endmodule

>>> rtl/lppd_parse.sv
// Parser core: framing state and per-byte decode.
// Depends on lppd_pkg.
`timescale 1ns / 1ps
module lppd_parse #(
  parameter int LENGTH_BITS = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data_in,
  input  logic                pend,
  output logic                res_valid,
  output lppd_pkg::result_t   res
);

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_DIGITS,
    PH_BADLEN,
    PH_TYPE,
    PH_DATA
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [2:0]             type_r, type_nxt;
  logic                   halted_r, halted_nxt;

  logic                   is_digit;
  logic [3:0]             digit;
  logic [7:0]             diff;
  logic [LENGTH_BITS+3:0] acc;
  logic                   acc_ovf;
  logic [LENGTH_BITS-1:0] rem_dec;

  assign is_digit = (data_in >= lppd_pkg::CHAR_ZERO) && (data_in <= lppd_pkg::CHAR_NINE);
  assign diff     = data_in - lppd_pkg::CHAR_ZERO;
  assign digit    = diff[3:0];
  // rem * 10 + digit, four bits of headroom
  assign acc      = ({4'b0, rem_r} << 3) + ({4'b0, rem_r} << 1)
                  + {{LENGTH_BITS{1'b0}}, digit};
  assign acc_ovf  = |acc[LENGTH_BITS+3:LENGTH_BITS];
  assign rem_dec  = rem_r - {{(LENGTH_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    phase_nxt  = phase_r;
    rem_nxt    = rem_r;
    type_nxt   = type_r;
    halted_nxt = halted_r;
    res_valid  = 1'b0;
    res        = '0;
    if (!halted_r) begin
      unique case (phase_r)
        PH_FIRST: begin
          if (is_digit) begin
            rem_nxt   = {{(LENGTH_BITS-4){1'b0}}, digit};
            phase_nxt = PH_DIGITS;
          end else begin
            phase_nxt = PH_BADLEN;
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            if (acc_ovf) phase_nxt = PH_BADLEN;
            else rem_nxt = acc[LENGTH_BITS-1:0];
          end else if (data_in == lppd_pkg::CHAR_COLON) begin
            if (rem_r == '0 || pend) begin
              res_valid  = 1'b1;
              res.status = lppd_pkg::STATUS_ERROR;
              halted_nxt = 1'b1;
            end else begin
              phase_nxt = PH_TYPE;
            end
          end else begin
            phase_nxt = PH_BADLEN;
          end
        end
        PH_BADLEN: begin
          if (data_in == lppd_pkg::CHAR_COLON) begin
            res_valid  = 1'b1;
            res.status = lppd_pkg::STATUS_ERROR;
            halted_nxt = 1'b1;
          end
        end
        PH_TYPE: begin
          if (!is_digit) begin
            res_valid  = 1'b1;
            res.status = lppd_pkg::STATUS_ERROR;
            halted_nxt = 1'b1;
          end else if (data_in > lppd_pkg::CHAR_SIX) begin
            res_valid  = 1'b1;
            res.status = lppd_pkg::STATUS_BADTYPE;
            halted_nxt = 1'b1;
          end else begin
            type_nxt = digit[2:0];
            rem_nxt  = rem_dec;
            if (rem_dec == '0 || pend) begin
              res_valid       = 1'b1;
              res.packet_type = digit[2:0];
              res.packet_last = 1'b1;
              res.status      = lppd_pkg::STATUS_OK;
              phase_nxt       = PH_FIRST;
              rem_nxt         = '0;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          rem_nxt         = rem_dec;
          res_valid       = 1'b1;
          res.packet_type = type_r;
          res.data_byte   = data_in;
          res.has_data    = 1'b1;
          res.packet_last = (rem_dec == '0) || pend;
          res.status      = lppd_pkg::STATUS_OK;
          if (res.packet_last) begin
            phase_nxt = PH_FIRST;
            rem_nxt   = '0;
          end
        end
        default: begin
          phase_nxt = PH_FIRST;
          rem_nxt   = '0;
        end
      endcase
    end
    if (pend) begin
      phase_nxt  = PH_FIRST;
      rem_nxt    = '0;
      type_nxt   = '0;
      halted_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      rem_r    <= '0;
      type_r   <= '0;
      halted_r <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      rem_r    <= rem_nxt;
      type_r   <= type_nxt;
      halted_r <= halted_nxt;
    end
  end

endmodule

>>> bench/tb.sv
// Self-checking testbench for length_prefixed_packet_deframer.
// Holds a small scoreboard class that predicts each result word, plus the top module tb.
// Depends on lppd_pkg and the deframer RTL only.
`timescale 1ns / 1ps

class deframe_checker #(int LEN_BITS = 20);
  typedef enum logic [2:0] {
    P_FIRST, P_DIGITS, P_BADLEN, P_TYPE, P_DATA
  } parse_phase_t;

  localparam longint unsigned LEN_MAX = (64'd1 << LEN_BITS) - 1;

  parse_phase_t         phase;
  logic [LEN_BITS-1:0]  remaining;
  logic [2:0]           cur_type;
  bit                   halted;
  lppd_pkg::result_t    awaited[$];
  int                   errors;
  int                   checked;

  function new();
    restart();
    errors  = 0;
    checked = 0;
  endfunction

  function void restart();
    phase     = P_FIRST;
    remaining = '0;
    cur_type  = '0;
    halted    = 1'b0;
  endfunction

  function int waiting();
    return awaited.size();
  endfunction

  // Advance the framing state by one accepted byte; queue the word it causes.
  function void take_payload_byte(logic [7:0] b, logic e);
    lppd_pkg::result_t r;
    bit                emit;
    bit                digit;
    bit                ends_here;
    longint unsigned   acc;
    r     = '0;
    emit  = 1'b0;
    digit = (b >= lppd_pkg::CHAR_ZERO) && (b <= lppd_pkg::CHAR_NINE);
    if (!halted) begin
      case (phase)
        P_FIRST: begin
          if (digit) begin
            remaining = LEN_BITS'(b - lppd_pkg::CHAR_ZERO);
            phase     = P_DIGITS;
          end else begin
            phase = P_BADLEN;
          end
        end
        P_DIGITS: begin
          if (digit) begin
            acc = 64'(remaining);
            acc = acc * 10 + 64'(b) - 64'(lppd_pkg::CHAR_ZERO);
            if (acc > LEN_MAX) phase = P_BADLEN;
            else remaining = acc[LEN_BITS-1:0];
          end else if (b == lppd_pkg::CHAR_COLON) begin
            if (remaining == 0 || e) begin
              r.status = lppd_pkg::STATUS_ERROR;
              emit     = 1'b1;
              halted   = 1'b1;
            end else begin
              phase = P_TYPE;
            end
          end else begin
            phase = P_BADLEN;
          end
        end
        P_BADLEN: begin
          if (b == lppd_pkg::CHAR_COLON) begin
            r.status = lppd_pkg::STATUS_ERROR;
            emit     = 1'b1;
            halted   = 1'b1;
          end
        end
        P_TYPE: begin
          if (!digit) begin
            r.status = lppd_pkg::STATUS_ERROR;
            emit     = 1'b1;
            halted   = 1'b1;
          end else if (b > lppd_pkg::CHAR_SIX) begin
            r.status = lppd_pkg::STATUS_BADTYPE;
            emit     = 1'b1;
            halted   = 1'b1;
          end else begin
            cur_type  = 3'(b - lppd_pkg::CHAR_ZERO);
            remaining = remaining - 1'b1;
            if (remaining == 0 || e) begin
              r.packet_type = cur_type;
              r.packet_last = 1'b1;
              r.status      = lppd_pkg::STATUS_OK;
              emit          = 1'b1;
              phase         = P_FIRST;
              remaining     = '0;
            end else begin
              phase = P_DATA;
            end
          end
        end
        P_DATA: begin
          remaining     = remaining - 1'b1;
          ends_here     = (remaining == 0) || e;
          r.packet_type = cur_type;
          r.data_byte   = b;
          r.has_data    = 1'b1;
          r.packet_last = ends_here;
          r.status      = lppd_pkg::STATUS_OK;
          emit          = 1'b1;
          if (ends_here) begin
            phase     = P_FIRST;
            remaining = '0;
          end
        end
        default: begin
          phase     = P_FIRST;
          remaining = '0;
        end
      endcase
    end
    if (emit) awaited = {awaited, r};
    if (e) restart();
  endfunction

  task report(string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  task check_result(lppd_pkg::result_t got);
    lppd_pkg::result_t want;
    if (awaited.size() == 0) begin
      report($sformatf("result word %h with nothing awaited", got));
      return;
    end
    want = awaited.pop_front();
    checked++;
    if (got.packet_type !== want.packet_type)
      report($sformatf("packet_type %0d, want %0d", got.packet_type, want.packet_type));
    if (got.data_byte !== want.data_byte)
      report($sformatf("data_byte %h, want %h", got.data_byte, want.data_byte));
    if (got.has_data !== want.has_data)
      report($sformatf("has_data %b, want %b", got.has_data, want.has_data));
    if (got.packet_last !== want.packet_last)
      report($sformatf("packet_last %b, want %b", got.packet_last, want.packet_last));
    if (got.status !== want.status)
      report($sformatf("status %0d, want %0d", got.status, want.status));
  endtask
endclass

module tb;

  localparam int         LEN_BITS     = 20;
  localparam int         IDLE_PCT     = 26;
  localparam int         RANDOM_WORDS = 900;
  localparam logic [7:0] CHAR_LOWER_B = 8'h62;

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              in_valid        = 1'b0;
  logic              in_stall;
  logic [7:0]        in_payload_byte = 8'h00;
  logic              in_payload_end  = 1'b0;
  logic              out_valid;
  logic              out_stall       = 1'b0;
  logic [2:0]        out_packet_type;
  logic [7:0]        out_data_byte;
  logic              out_has_data;
  logic              out_packet_last;
  logic [1:0]        out_status;
  lppd_pkg::result_t seen_word;

  deframe_checker #(LEN_BITS) sb;

  // Bytes of the payload being built, sent front to back.
  logic [7:0] payload_q[$];
  bit         idle_free      = 1'b0;
  int         words_sent     = 0;
  int         payloads_sent  = 0;
  int         directed_words = 0;
  int         random_base    = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  length_prefixed_packet_deframer #(
    .LENGTH_BITS(LEN_BITS)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_payload_byte (in_payload_byte),
    .in_payload_end  (in_payload_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_packet_type (out_packet_type),
    .out_data_byte   (out_data_byte),
    .out_has_data    (out_has_data),
    .out_packet_last (out_packet_last),
    .out_status      (out_status)
  );

  assign seen_word = {out_packet_type, out_data_byte, out_has_data, out_packet_last, out_status};

  // Receiver: stall at random, except during the quiet stretch.
  always @(negedge clk) begin
    out_stall <= !idle_free && ($urandom_range(99) < IDLE_PCT);
  end

  // Sample both channels at the rising edge: predict on every accepted input
  // word, compare every accepted result word against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.take_payload_byte(in_payload_byte, in_payload_end);
    if (rst_n && out_valid && !out_stall) sb.check_result(seen_word);
  end

  // Offer one word, with random idle cycles ahead of it, and hold it until
  // the block takes it. Return at the falling edge after acceptance.
  task automatic send_word(input logic [7:0] b, input logic e);
    while (!idle_free && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_payload_byte <= b;
    in_payload_end  <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // Send the built payload; mark its final byte as the payload end.
  task automatic send_payload();
    foreach (payload_q[i]) send_word(payload_q[i], i == payload_q.size() - 1);
    payloads_sent++;
  endtask

  // Drop valid and hold off until every predicted word has come out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.waiting() != 0);
  endtask

  // Append one byte to the payload under construction.
  function automatic void add_byte(logic [7:0] b);
    payload_q = {payload_q, b};
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] any_nondigit();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b >= lppd_pkg::CHAR_ZERO && b <= lppd_pkg::CHAR_NINE);
    return b;
  endfunction

  // Well-framed packet: decimal length, colon, type char, len-1 random data bytes.
  function automatic void push_packet(int unsigned len, logic [7:0] type_char);
    push_text($sformatf("%0d:", len));
    add_byte(type_char);
    for (int i = 1; i < len; i++) add_byte(8'($urandom_range(255)));
  endfunction

  // Mostly well-framed packets with random content; the rest are broken
  // lengths, zero lengths, bad types, overflowing and maximum lengths and raw noise.
  // Sometimes append loose trailing bytes or cut the payload short.
  function automatic void build_random_payload();
    int n_pkts;
    int keep;
    payload_q.delete();
    n_pkts = $urandom_range(1, 4);
    repeat (n_pkts) begin
      if ($urandom_range(99) < 82) begin
        push_packet(($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8),
                    8'(lppd_pkg::CHAR_ZERO + $urandom_range(6)));
      end else begin
        case ($urandom_range(6))
          0: begin
            push_text($sformatf("%0d", $urandom_range(1, 99)));
            add_byte(any_nondigit());
            push_text(":1");
          end
          1: push_text("00:3");
          2: push_packet($urandom_range(1, 5),
                         8'(lppd_pkg::CHAR_ZERO + $urandom_range(7, 9)));
          3: push_packet($urandom_range(1, 5),
                         $urandom_range(1) ? CHAR_LOWER_B : any_nondigit());
          4: push_text($sformatf("%0d:5", (1 << LEN_BITS) + $urandom_range(0, 8000000)));
          5: push_text($sformatf("%0d:2", (1 << LEN_BITS) - 1));
          default: repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(255)));
        endcase
      end
    end
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 4)) add_byte(any_nondigit());
    end
    if ($urandom_range(6) == 0) begin
      keep = $urandom_range(1, payload_q.size());
      while (payload_q.size() > keep) void'(payload_q.pop_back());
    end
  endfunction

  initial begin
    sb = new();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed payloads: data byte extremes, every error kind, cut-short packets.
    payload_q.delete(); push_text("3:6"); add_byte(8'h00);
    add_byte(8'hFF); send_payload();
    payload_q.delete(); push_text("0:");       send_payload();  // zero length
    payload_q.delete(); push_text("::");       send_payload();  // empty length
    payload_q.delete(); push_text("2:9z");     send_payload();  // type above six
    payload_q.delete(); push_text("2:b");      send_payload();  // letter as type
    payload_q.delete(); push_text("1048576:"); send_payload();  // length overflow
    payload_q.delete(); push_text("5:1x");     send_payload();  // cut short in data
    payload_q.delete(); push_text("4:");       send_payload();  // colon is final byte
    payload_q.delete(); push_text("1:312");    send_payload();  // type only, then loose bytes
    drain();
    directed_words = words_sent;
    random_base    = words_sent;

    // Random payloads; a quiet stretch with no idling on either side, and a
    // full drain every dozen payloads.
    while (words_sent < directed_words + RANDOM_WORDS) begin
      idle_free = (words_sent - random_base >= 300) && (words_sent - random_base < 450);
      build_random_payload();
      send_payload();
      if (payloads_sent % 12 == 0) drain();
    end
    idle_free = 1'b0;

    drain();
    repeat (20) @(negedge clk);

    $display("Sent %0d payloads, %0d bytes; compared %0d result words, %0d mismatches.",
             payloads_sent, words_sent, sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #2000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
rtl/lppd_pkg.sv
rtl/lppd_parse.sv
rtl/length_prefixed_packet_deframer.sv
bench/tb.sv
